FILE: src/tcgr_pkg.sv
// Shared types and constants for the text console glyph renderer.
// Holds character codes, op codes, register indexes and the control structs
// that pass between the controller and the datapath. No dependencies.
`default_nettype none

package tcgr_pkg;

  // Default build values for the top-level parameters.
  localparam int GLYPH_LINES_MAX_DEF = 16;
  localparam int FONT_CHARS_DEF      = 256;
  localparam int BYTES_PER_PIXEL_DEF = 4;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_IDX_W   = 3;

  // Operations carried in the op field.
  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_HOME = 2'd2;

  // Control characters.
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_NL  = 8'h0A;

  localparam logic [10:0] TAB_STEP   = 11'd4;
  localparam logic [3:0]  PIXELS_MAX = 4'd8;
  localparam logic [11:0] ROW_MAX    = 12'd4095;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CSR_FB_BASE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CSR_LINE_PITCH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CSR_TEXT_COLUMNS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CSR_GLYPH_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CSR_GLYPH_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CSR_FG_COLOR      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CSR_BG_COLOR      = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // capture the input word
    logic decode;   // apply the captured item to cursor and font store
    logic mul1;     // cell position in pixels
    logic mul2;     // line offset in bytes, visibility check
    logic prime;    // form the first row address, read the first font row
    logic emit;     // load one row into the output register
  } tcgr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic draw;      // the captured item draws a cell
    logic visible;   // the first glyph row lies on screen
    logic last;      // the current row is the final one of the cell
    logic out_free;  // the output register can take a row this cycle
  } tcgr_status_t;

endpackage

`default_nettype wire

FILE: src/tcgr_ctrl.sv
// Controller state machine of the text console glyph renderer.
// Sequences decode, address setup and row emission; depends on tcgr_pkg.
`default_nettype none

module tcgr_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire tcgr_pkg::tcgr_status_t status,
  output tcgr_pkg::tcgr_cmd_t        cmd
);
  import tcgr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MUL1   = 3'd2;
  localparam logic [2:0] S_MUL2   = 3'd3;
  localparam logic [2:0] S_ADDR   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = status.draw ? S_MUL1 : S_IDLE;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        // A cell that starts below the screen gives no rows.
        cmd.prime  = status.visible;
        state_next = status.visible ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free && status.last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/tcgr_datapath.sv
// Datapath of the text console glyph renderer: configuration registers,
// cursor, font memory, address arithmetic and the output register.
// Depends on tcgr_pkg; driven by tcgr_ctrl through command signals.
`default_nettype none

module tcgr_datapath #(
  parameter int GLYPH_LINES_MAX = tcgr_pkg::GLYPH_LINES_MAX_DEF,
  parameter int FONT_CHARS      = tcgr_pkg::FONT_CHARS_DEF,
  parameter int BYTES_PER_PIXEL = tcgr_pkg::BYTES_PER_PIXEL_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [tcgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [tcgr_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [tcgr_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                   m_tlast,
  input  wire tcgr_pkg::tcgr_cmd_t               cmd,
  output tcgr_pkg::tcgr_status_t                 status
);
  import tcgr_pkg::*;

  localparam int FONT_DEPTH = FONT_CHARS * GLYPH_LINES_MAX;
  localparam int FA_W       = $clog2(FONT_DEPTH);
  localparam int GH_MAX     = (GLYPH_LINES_MAX < 16) ? GLYPH_LINES_MAX : 16;

  // Configuration registers. The colour registers feed nothing in the
  // row words, so writes to them are accepted and dropped.
  logic [47:0] fb_base;
  logic [15:0] line_pitch;
  logic [10:0] text_columns;
  logic [12:0] screen_height;
  logic [3:0]  glyph_width;
  logic [4:0]  glyph_height;

  // Captured input word.
  logic [1:0] it_op;
  logic [7:0] it_code;
  logic [3:0] it_line;
  logic [7:0] it_bits;

  // Cursor.
  logic [9:0]  cur_col;
  logic [11:0] cur_row;

  // Cell being drawn.
  logic [9:0]      draw_col;
  logic [11:0]     draw_row;
  logic            blank;
  logic [FA_W-1:0] glyph_base;
  logic [15:0]     y0;
  logic [12:0]     xpix;
  logic [31:0]     yoff;
  logic [15:0]     xb;
  logic            visible;
  logic [47:0]     row_addr;
  logic [15:0]     line;
  logic [4:0]      idx;

  logic [7:0] font_mem [FONT_DEPTH];
  logic [7:0] rd_data;

  // Clamped register values.
  logic [10:0] cols_c;
  logic [12:0] sh_c;
  logic [3:0]  gw_c;
  logic [4:0]  gh_c;
  logic [7:0]  keep;

  always_comb begin
    if (text_columns < 11'd4) begin
      cols_c = 11'd4;
    end else if (text_columns > 11'd1024) begin
      cols_c = 11'd1024;
    end else begin
      cols_c = text_columns;
    end
    if (screen_height == 13'd0) begin
      sh_c = 13'd1;
    end else if (screen_height > 13'd4096) begin
      sh_c = 13'd4096;
    end else begin
      sh_c = screen_height;
    end
    if (glyph_width == 4'd0) begin
      gw_c = 4'd1;
    end else if (glyph_width > PIXELS_MAX) begin
      gw_c = PIXELS_MAX;
    end else begin
      gw_c = glyph_width;
    end
    if (glyph_height == 5'd0) begin
      gh_c = 5'd1;
    end else if (glyph_height > 5'(GH_MAX)) begin
      gh_c = 5'(GH_MAX);
    end else begin
      gh_c = glyph_height;
    end
    keep = 8'hFF << (PIXELS_MAX - gw_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_base       <= '0;
      line_pitch    <= 16'd4096;
      text_columns  <= 11'd128;
      screen_height <= 13'd768;
      glyph_width   <= 4'd8;
      glyph_height  <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CSR_FB_BASE:       fb_base       <= cfg_data[47:0];
        CSR_LINE_PITCH:    line_pitch    <= cfg_data[15:0];
        CSR_TEXT_COLUMNS:  text_columns  <= cfg_data[10:0];
        CSR_SCREEN_HEIGHT: screen_height <= cfg_data[12:0];
        CSR_GLYPH_WIDTH:   glyph_width   <= cfg_data[3:0];
        CSR_GLYPH_HEIGHT:  glyph_height  <= cfg_data[4:0];
        CSR_FG_COLOR, CSR_BG_COLOR: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_op   <= s_tdata[1:0];
      it_code <= s_tdata[9:2];
      it_line <= s_tdata[13:10];
      it_bits <= s_tdata[21:14];
    end
  end

  // Cursor decode for a put-character item.
  logic [9:0]  wcol;
  logic [11:0] wrow;
  logic [11:0] wrow_inc;
  logic [10:0] tab_sum;
  logic [10:0] col_inc;
  logic [9:0]  col_next;
  logic [11:0] row_next;
  logic [9:0]  dcol;
  logic [11:0] drow;
  logic        put_active;
  logic        draw;
  logic        draw_blank;
  logic [8:0]  code9;
  logic [8:0]  glyph_idx;

  always_comb begin
    put_active = (it_op == OP_PUT) && (it_code != CHAR_NUL);
    // A column left beyond a shrunken row width wraps first.
    if ({1'b0, cur_col} >= cols_c) begin
      wcol = '0;
      wrow = (cur_row == ROW_MAX) ? cur_row : cur_row + 12'd1;
    end else begin
      wcol = cur_col;
      wrow = cur_row;
    end
    wrow_inc   = (wrow == ROW_MAX) ? wrow : wrow + 12'd1;
    tab_sum    = {1'b0, wcol} + TAB_STEP;
    col_inc    = {1'b0, wcol} + 11'd1;
    col_next   = wcol;
    row_next   = wrow;
    dcol       = wcol;
    drow       = wrow;
    draw       = 1'b0;
    draw_blank = 1'b0;
    case (it_code)
      CHAR_NL: begin
        col_next = '0;
        row_next = wrow_inc;
      end
      CHAR_TAB: begin
        if (tab_sum >= cols_c) begin
          col_next = 10'(tab_sum - cols_c);
          row_next = wrow_inc;
        end else begin
          col_next = tab_sum[9:0];
        end
      end
      CHAR_BS: begin
        // Backspace at home does nothing at all.
        if (!(wcol == '0 && wrow == '0)) begin
          draw       = 1'b1;
          draw_blank = 1'b1;
          if (wcol == '0) begin
            col_next = 10'(cols_c - 11'd1);
            row_next = wrow - 12'd1;
          end else begin
            col_next = wcol - 10'd1;
          end
          dcol = col_next;
          drow = row_next;
        end
      end
      default: begin
        draw = 1'b1;
        if (col_inc >= cols_c) begin
          col_next = '0;
          row_next = wrow_inc;
        end else begin
          col_next = col_inc[9:0];
        end
      end
    endcase
    draw  = draw && put_active;
    code9 = {1'b0, it_code};
    glyph_idx = (code9 >= 9'(FONT_CHARS)) ? code9 - 9'(FONT_CHARS) : code9;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.decode) begin
      if (it_op == OP_HOME) begin
        cur_col <= '0;
        cur_row <= '0;
      end else if (put_active) begin
        cur_col <= col_next;
        cur_row <= row_next;
      end
    end
  end

  // Font store writes and the one read port.
  logic            font_we;
  logic [FA_W-1:0] wr_addr;
  logic [4:0]      idx_inc;
  logic [4:0]      rd_idx;
  logic            rd_en;
  logic [FA_W-1:0] rd_addr;

  always_comb begin
    font_we = cmd.decode && (it_op == OP_LOAD) && (code9 < 9'(FONT_CHARS)) &&
              ({2'b0, it_line} < 6'(GLYPH_LINES_MAX));
    wr_addr = FA_W'(it_code) * FA_W'(GLYPH_LINES_MAX) + FA_W'(it_line);
    idx_inc = idx + 5'd1;
    rd_idx  = cmd.prime ? 5'd0 : idx_inc;
    rd_en   = cmd.prime || (cmd.emit && (idx_inc < gh_c));
    rd_addr = glyph_base + FA_W'(rd_idx);
  end

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[wr_addr] <= it_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= font_mem[rd_addr];
    end
  end

  // Address setup: cell position, line offset, then the first row address.
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      draw_col   <= dcol;
      draw_row   <= drow;
      blank      <= draw_blank;
      glyph_base <= FA_W'(glyph_idx) * FA_W'(GLYPH_LINES_MAX);
    end
    if (cmd.mul1) begin
      y0   <= 16'(draw_row) * 16'(gh_c);
      xpix <= 13'(draw_col) * 13'(gw_c);
    end
    if (cmd.mul2) begin
      yoff    <= 32'(y0) * 32'(line_pitch);
      xb      <= 16'(xpix) * 16'(BYTES_PER_PIXEL);
      visible <= (y0 < 16'(sh_c));
    end
    if (cmd.prime) begin
      row_addr <= fb_base + 48'(yoff) + 48'(xb);
      line     <= y0;
      idx      <= '0;
    end else if (cmd.emit) begin
      row_addr <= row_addr + 48'(line_pitch);
      line     <= line + 16'd1;
      idx      <= idx_inc;
    end
  end

  // A row is the last when the glyph ends or the next line is off screen.
  logic last;
  assign last = ({1'b0, idx} + 6'd1 == {1'b0, gh_c}) ||
                ({1'b0, line} + 17'd1 >= 17'(sh_c));

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {4'b0, gw_c, (blank ? 8'h00 : (rd_data & keep)), row_addr};
      m_tlast <= last;
    end
  end

  assign status.draw     = draw;
  assign status.visible  = visible;
  assign status.last     = last;
  assign status.out_free = out_free;

endmodule

`default_nettype wire

FILE: src/text_console_glyph_renderer.sv
// Text console glyph renderer: cursor handling and glyph row words.
// A printed character's first row word follows the decode, MUL1, MUL2 and ADDR
// states after the word is accepted, then one row per cycle while the output
// is taken; the font memory read and the row-address adder set this pace.
// No new word is taken until the previous item and any rows of its cell are done.
// Synchronous reset restores register defaults and homes the cursor; the
// font memory is not cleared and holds undefined data until loaded.
`default_nettype none

module text_console_glyph_renderer #(
  parameter int GLYPH_LINES_MAX = tcgr_pkg::GLYPH_LINES_MAX_DEF,
  parameter int FONT_CHARS      = tcgr_pkg::FONT_CHARS_DEF,
  parameter int BYTES_PER_PIXEL = tcgr_pkg::BYTES_PER_PIXEL_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [tcgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // op [1:0], char_code [9:2], font_line [13:10], font_bits [21:14]
  input  wire logic [tcgr_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // row_address [47:0], pixel_bits [55:48], pixel_count [59:56]
  output logic [tcgr_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                   m_tlast
);
  import tcgr_pkg::*;

  tcgr_cmd_t    cmd;
  tcgr_status_t status;

  tcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tcgr_datapath #(
    .GLYPH_LINES_MAX (GLYPH_LINES_MAX),
    .FONT_CHARS      (FONT_CHARS),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
